FILE: hw/rtl/zspd_pkg.sv
// ----------------------------------------------------------------------------
// zspd_pkg
// Shared types and constants for the smoothed z-score peak detector.
// ----------------------------------------------------------------------------
package zspd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 8;
    localparam int FLAG_W   = 2;
    localparam int SD_W     = 15;
    // Population variance of 16-bit values is below 2^30.
    localparam int VAR_W    = 30;

    localparam int DIV_STEPS  = VAR_W;
    localparam int SQRT_STEPS = VAR_W / 2;
    localparam int STEP_W     = 5;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd56;

    localparam logic signed [FLAG_W-1:0] FLAG_NONE = 2'sb00;
    localparam logic signed [FLAG_W-1:0] FLAG_HIGH = 2'sb01;
    localparam logic signed [FLAG_W-1:0] FLAG_LOW  = 2'sb11;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_READ   = 10'b00_0000_0010,
        S_FILTER = 10'b00_0000_0100,
        S_ACCUM  = 10'b00_0000_1000,
        S_MUL    = 10'b00_0001_0000,
        S_PREP   = 10'b00_0010_0000,
        S_DIV    = 10'b00_0100_0000,
        S_SQINIT = 10'b00_1000_0000,
        S_SQRT   = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic read_win;
        logic filter;
        logic accum;
        logic mul;
        logic prep;
        logic div_step;
        logic sq_init;
        logic sq_step;
        logic finish;
    } dp_cmd_t;

endpackage

FILE: hw/rtl/zspd_ctrl.sv
// ----------------------------------------------------------------------------
// zspd_ctrl
// Sequencer: walks one sample through filter, update, divide and square root.
// ----------------------------------------------------------------------------
module zspd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output zspd_pkg::dp_cmd_t cmd
);
    import zspd_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_win = 1'b1;
                state_next   = S_FILTER;
            end
            S_FILTER:
            begin
                cmd.filter = 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_SQINIT;
                else
                    step_next = step_reg + 1'b1;
            end
            S_SQINIT:
            begin
                cmd.sq_init = 1'b1;
                step_next   = '0;
                state_next  = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    state_next = S_DONE;
                else
                    step_next = step_reg + 1'b1;
            end
            S_DONE:
            begin
                // hold until the output register is free or being drained
                if (!m_valid_reg || m_tready)
                begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hw/rtl/zspd_datapath.sv
// ----------------------------------------------------------------------------
// zspd_datapath
// Window memory, running sums, shared-step dividers and square root.
// ----------------------------------------------------------------------------
module zspd_datapath #(
    parameter int LAG = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  zspd_pkg::dp_cmd_t                     cmd,
    input  logic                                  threshold_we,
    input  logic [zspd_pkg::THR_W-1:0]            threshold_wdata,
    input  logic [zspd_pkg::SAMPLE_W-1:0]         sample,
    output logic signed [zspd_pkg::FLAG_W-1:0]    peak_flag,
    output logic [zspd_pkg::SAMPLE_W-1:0]         filtered_sample,
    output logic [zspd_pkg::SAMPLE_W-1:0]         window_mean,
    output logic [zspd_pkg::SD_W-1:0]             window_sd
);
    import zspd_pkg::*;

    localparam int PTR_W  = $clog2(LAG);
    localparam int CNT_W  = $clog2(LAG + 1);
    localparam int SUM_W  = SAMPLE_W + PTR_W;
    localparam int SQ_W   = 2 * SAMPLE_W + PTR_W;
    localparam int NUM_W  = SQ_W + CNT_W;
    localparam int SS_W   = 2 * SUM_W;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int VDIV_W = DEN_W + VAR_W - 1;
    localparam int VCMP_W = (NUM_W > VDIV_W) ? NUM_W : VDIV_W;
    localparam int MDIV_W = CNT_W + VAR_W - 1;
    localparam int MCMP_W = (SUM_W > MDIV_W) ? SUM_W : MDIV_W;
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int TSD_W  = THR_W + SD_W;

    // state with defined reset
    logic [THR_W-1:0]    thr_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [PTR_W-1:0]    wptr_reg;
    logic [SAMPLE_W-1:0] last_reg;
    logic [SAMPLE_W-1:0] pmean_reg;
    logic [SD_W-1:0]     psd_reg;

    // working registers
    logic [SAMPLE_W-1:0] win_mem [LAG];
    logic [SAMPLE_W-1:0] rd_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic                x_gt_reg;
    logic [SAMPLE_W-1:0] dist_reg;
    logic [TSD_W-1:0]    tsd_reg;
    logic [SAMPLE_W-1:0] old_reg, v_reg;
    logic [PROD_W-1:0]   old_sq_reg, v_sq_reg;
    logic signed [FLAG_W-1:0] flag_reg;
    logic [NUM_W-1:0]    p_ns_reg;
    logic [SS_W-1:0]     p_ss_reg;
    logic [DEN_W-1:0]    p_nn_reg;
    logic [NUM_W-1:0]    vrem_reg;
    logic [VDIV_W-1:0]   vdiv_reg;
    logic [VAR_W-1:0]    vq_reg;
    logic [SUM_W-1:0]    mrem_reg;
    logic [MDIV_W-1:0]   mdiv_reg;
    logic [VAR_W-1:0]    mq_reg;
    logic [VAR_W-1:0]    sv_reg, sres_reg, sbit_reg;

    logic signed [FLAG_W-1:0] out_flag_reg;
    logic [SAMPLE_W-1:0] out_filt_reg, out_mean_reg;
    logic [SD_W-1:0]     out_sd_reg;

    // combinational helpers
    logic                full;
    logic                anomaly;
    logic [SAMPLE_W-1:0] v_sel, old_sel;
    logic [VCMP_W-1:0]   vrem_ext, vdiv_ext;
    logic                vge;
    logic [MCMP_W-1:0]   mrem_ext, mdiv_ext;
    logic                mge;
    logic [VAR_W-1:0]    s_trial;
    logic                sge;
    logic [SAMPLE_W-1:0] mean_val;
    logic [SD_W-1:0]     sd_val;

    assign full    = (fill_reg == CNT_W'(LAG));
    assign anomaly = full && (TSD_W'({dist_reg, 4'b0000}) > tsd_reg);
    assign v_sel   = anomaly ? last_reg : x_reg;
    assign old_sel = full ? rd_reg : '0;

    assign sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(v_reg);
    assign sq_next  = sq_reg - SQ_W'(old_sq_reg) + SQ_W'(v_sq_reg);

    assign vrem_ext = VCMP_W'(vrem_reg);
    assign vdiv_ext = VCMP_W'(vdiv_reg);
    assign vge      = (vrem_ext >= vdiv_ext);
    assign mrem_ext = MCMP_W'(mrem_reg);
    assign mdiv_ext = MCMP_W'(mdiv_reg);
    assign mge      = (mrem_ext >= mdiv_ext);

    assign s_trial  = sres_reg + sbit_reg;
    assign sge      = (sv_reg >= s_trial);

    assign mean_val = mq_reg[SAMPLE_W-1:0];
    assign sd_val   = sres_reg[SD_W-1:0];

    assign peak_flag       = out_flag_reg;
    assign filtered_sample = out_filt_reg;
    assign window_mean     = out_mean_reg;
    assign window_sd       = out_sd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THRESHOLD_RESET;
            sum_reg   <= '0;
            sq_reg    <= '0;
            fill_reg  <= '0;
            wptr_reg  <= '0;
            last_reg  <= '0;
            pmean_reg <= '0;
            psd_reg   <= '0;
        end
        else
        begin
            if (threshold_we)
                thr_reg <= threshold_wdata;
            if (cmd.filter)
            begin
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
                if (wptr_reg == PTR_W'(LAG - 1))
                    wptr_reg <= '0;
                else
                    wptr_reg <= wptr_reg + 1'b1;
            end
            if (cmd.accum)
            begin
                sum_reg <= sum_next;
                sq_reg  <= sq_next;
            end
            if (cmd.finish)
            begin
                last_reg  <= v_reg;
                pmean_reg <= mean_val;
                psd_reg   <= sd_val;
            end
        end
    end

    // window memory: one read or one write per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.read_win)
            rd_reg <= win_mem[wptr_reg];
        if (cmd.filter)
            win_mem[wptr_reg] <= v_sel;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            x_reg <= sample;

        if (cmd.read_win)
        begin
            x_gt_reg <= (x_reg > pmean_reg);
            dist_reg <= (x_reg > pmean_reg) ? (x_reg - pmean_reg) : (pmean_reg - x_reg);
            tsd_reg  <= TSD_W'(thr_reg) * TSD_W'(psd_reg);
        end

        if (cmd.filter)
        begin
            v_reg      <= v_sel;
            old_reg    <= old_sel;
            v_sq_reg   <= PROD_W'(v_sel) * PROD_W'(v_sel);
            old_sq_reg <= PROD_W'(old_sel) * PROD_W'(old_sel);
            if (anomaly)
                flag_reg <= x_gt_reg ? FLAG_HIGH : FLAG_LOW;
            else
                flag_reg <= FLAG_NONE;
        end

        if (cmd.mul)
        begin
            p_ns_reg <= NUM_W'(fill_reg) * NUM_W'(sq_reg);
            p_ss_reg <= SS_W'(sum_reg) * SS_W'(sum_reg);
            p_nn_reg <= DEN_W'(fill_reg) * DEN_W'(fill_reg);
        end

        if (cmd.prep)
        begin
            vrem_reg <= p_ns_reg - NUM_W'(p_ss_reg);
            vdiv_reg <= {p_nn_reg, {(VAR_W - 1){1'b0}}};
            vq_reg   <= '0;
            mrem_reg <= sum_reg;
            mdiv_reg <= {fill_reg, {(VAR_W - 1){1'b0}}};
            mq_reg   <= '0;
        end

        // one quotient bit per cycle for both divisions
        if (cmd.div_step)
        begin
            if (vge)
                vrem_reg <= NUM_W'(vrem_ext - vdiv_ext);
            vq_reg   <= {vq_reg[VAR_W-2:0], vge};
            vdiv_reg <= vdiv_reg >> 1;
            if (mge)
                mrem_reg <= SUM_W'(mrem_ext - mdiv_ext);
            mq_reg   <= {mq_reg[VAR_W-2:0], mge};
            mdiv_reg <= mdiv_reg >> 1;
        end

        if (cmd.sq_init)
        begin
            sv_reg   <= vq_reg;
            sres_reg <= '0;
            sbit_reg <= VAR_W'(1) << (VAR_W - 2);
        end

        // one result bit per cycle
        if (cmd.sq_step)
        begin
            if (sge)
            begin
                sv_reg   <= sv_reg - s_trial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end

        if (cmd.finish)
        begin
            out_flag_reg <= flag_reg;
            out_filt_reg <= v_reg;
            out_mean_reg <= mean_val;
            out_sd_reg   <= sd_val;
        end
    end

endmodule

FILE: hw/rtl/zscore_peak_detector.sv
// ----------------------------------------------------------------------------
// zscore_peak_detector
// Smoothed z-score peak detector over a sliding window of LAG samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one unsigned 16-bit sample (8 fraction bits) per transfer.
//   m_* channel: one result per sample: flag, filtered sample, window mean
//   and window standard deviation, both rounded down.
//   threshold_we/threshold_wdata: z-score threshold (4 fraction bits), write
//   only while no sample is in flight.
//   Each sample passes from its transfer to its result through window read,
//   filter, sum update, products and divider set-up, a shift-subtract divider
//   that produces mean and variance together, a square-root set-up step and
//   15 bit-by-bit steps of square root, and the load of the output register.
//   One sample is worked on at a time; the next is taken the cycle after the
//   result is loaded.
//   Reset clears the window sums, fill count, stored mean and deviation, and
//   loads threshold 56. The first LAG samples report flag 0.
//   A stalled receiver holds the result in the output register; a finished
//   sample then waits in its last step and s_tready stays low.
// ----------------------------------------------------------------------------
module zscore_peak_detector #(
    parameter int LAG = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        threshold_we,
    input  logic [7:0]  threshold_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata     // [1:0] peak_flag, [17:2] filtered_sample,
                                    // [33:18] window_mean, [48:34] window_sd,
                                    // [55:49] zero
);
    import zspd_pkg::*;

    dp_cmd_t                    cmd;
    logic signed [FLAG_W-1:0]   peak_flag;
    logic [SAMPLE_W-1:0]        filtered_sample;
    logic [SAMPLE_W-1:0]        window_mean;
    logic [SD_W-1:0]            window_sd;

    zspd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    zspd_datapath #(
        .LAG (LAG)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .sample          (s_tdata),
        .peak_flag       (peak_flag),
        .filtered_sample (filtered_sample),
        .window_mean     (window_mean),
        .window_sd       (window_sd)
    );

    assign m_tdata = {7'b000_0000, window_sd, window_mean, filtered_sample, peak_flag};

endmodule

FILE: sim/tb_zscore_peak_detector.sv
// ----------------------------------------------------------------------------
// tb_zscore_peak_detector
// Streams samples through the z-score peak detector under random sender gaps
// and receiver stalls. A built-in predictor keeps its own window, sums and
// threshold and checks the flag, filtered sample, mean and deviation of every
// result in order.
// ----------------------------------------------------------------------------
module tb_zscore_peak_detector;

    timeunit 1ns;
    timeprecision 1ps;

    import zspd_pkg::*;

    localparam int LAG          = 32;
    localparam int PHASE_ITEMS  = 72;
    localparam int MAX_REPORTS  = 10;
    localparam logic [7:0] THR_PLAN [8] = '{8'd0, 8'd255, 8'd16, 8'd1,
                                            8'd128, 8'd56, 8'd254, 8'd40};

    typedef enum int { RX_OPEN, RX_JITTER, RX_BURSTY } rx_mode_t;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic [6:0]  pad;
        logic [14:0] sd;
        logic [15:0] mean;
        logic [15:0] filtered;
        logic [1:0]  flag;
    } zs_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        threshold_we = 1'b0;
    logic [7:0]  threshold_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    // Predictor state
    logic [15:0]     win_entries [LAG];
    longint unsigned win_sum;
    longint unsigned win_sq_sum;
    int unsigned     fill_level;
    int unsigned     wr_ptr;
    longint unsigned last_kept;
    longint unsigned held_mean;
    longint unsigned held_sd;
    logic [7:0]      model_threshold;

    logic [15:0] sample_queue [$];
    zs_result_t  expected_results [$];
    int          fail_count = 0;

    int       burst_left;
    int       gap_left;
    rx_mode_t rx_mode;
    int       mode_left;
    int       stall_left;

    zscore_peak_detector #(
        .LAG (LAG)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic zs_result_t predict_step(input logic [15:0] smp);
        zs_result_t      res;
        longint unsigned x;
        longint unsigned kept;
        longint unsigned delta;
        longint unsigned old_val;
        longint unsigned n;
        longint unsigned variance;
        longint unsigned sd;
        x        = smp;
        kept     = x;
        res      = '0;
        res.flag = FLAG_NONE;
        if (fill_level >= LAG)
        begin
            delta = (x > held_mean) ? x - held_mean : held_mean - x;
            if (delta * 16 > longint'(model_threshold) * held_sd)
            begin
                res.flag = (x > held_mean) ? FLAG_HIGH : FLAG_LOW;
                kept     = last_kept;
            end
            // drop the oldest entry before the new one enters
            old_val    = win_entries[wr_ptr];
            win_sum    -= old_val;
            win_sq_sum -= old_val * old_val;
        end
        else
            fill_level++;
        win_entries[wr_ptr] = kept[15:0];
        win_sum    += kept;
        win_sq_sum += kept * kept;
        wr_ptr      = (wr_ptr + 1) % LAG;

        n        = fill_level;
        variance = (n * win_sq_sum - win_sum * win_sum) / (n * n);
        sd       = floor_sqrt(variance);
        if (sd > 64'h7FFF)
            sd = 64'h7FFF;
        last_kept = kept;
        held_mean = (win_sum / n) & 64'hFFFF;
        held_sd   = sd;

        res.filtered = kept[15:0];
        res.mean     = held_mean[15:0];
        res.sd       = sd[14:0];
        return res;
    endfunction

    task automatic queue_sample(input logic [15:0] smp);
        sample_queue.insert(sample_queue.size(), smp);
    endtask

    // Sender: bursts of random length, random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= 16'd0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0 || sample_queue.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_queue.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // Receiver: stall pattern that switches between open, jittery and bursty.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_mode    = RX_OPEN;
            mode_left  = 0;
            stall_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(100, 600);
            end
            else
                mode_left--;
            if (stall_left > 0)
                stall_left--;
            else
            begin
                case (rx_mode)
                    RX_JITTER:
                        if ($urandom_range(0, 2) == 0)
                            stall_left = $urandom_range(1, 4);
                    RX_BURSTY:
                        if ($urandom_range(0, 19) == 0)
                            stall_left = $urandom_range(10, 60);
                    default:
                        stall_left = 0;
                endcase
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Predict on every accepted sample transfer.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            expected_results.insert(expected_results.size(), predict_step(s_tdata));
    end

    always @(posedge clk)
    begin
        zs_result_t got;
        zs_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: flag %0d filtered %h mean %h sd %h",
                             $signed(got.flag), got.filtered, got.mean, got.sd);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.flag !== want.flag || got.filtered !== want.filtered ||
                    got.mean !== want.mean || got.sd !== want.sd || got.pad !== want.pad)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: flag %0d/%0d filtered %h/%h mean %h/%h",
                                  " sd %h/%h pad %h/%h (exp/act)"},
                                 $signed(want.flag), $signed(got.flag), want.filtered,
                                 got.filtered, want.mean, got.mean, want.sd, got.sd,
                                 want.pad, got.pad);
                end
            end
        end
    end

    // Hold until no sample is queued, on the bus or awaiting its result.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] thr);
        @(posedge clk);
        threshold_we    <= 1'b1;
        threshold_wdata <= thr;
        model_threshold  = thr;
        @(posedge clk);
        threshold_we    <= 1'b0;
    endtask

    initial
    begin
        int          base;
        int          spread;
        int          level;
        int          pick;
        logic [15:0] flat_level;
        logic [7:0]  thr;

        for (int i = 0; i < LAG; i++)
            win_entries[i] = 16'd0;
        win_sum         = 0;
        win_sq_sum      = 0;
        fill_level      = 0;
        wr_ptr          = 0;
        last_kept       = 0;
        held_mean       = 0;
        held_sd         = 0;
        model_threshold = THRESHOLD_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Warm-up from full scale to zero, then a steady level; then anomalies
        // on both sides and a sample right at the level, at reset threshold.
        queue_sample(16'hFFFF);
        queue_sample(16'h0000);
        for (int i = 0; i < LAG - 2; i++)
            queue_sample(16'h4000);
        queue_sample(16'hFFFF);
        queue_sample(16'h0000);
        queue_sample(16'h4000);
        queue_sample(16'h4001);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            thr = (ph == 5 || ph == 7) ? 8'($urandom_range(0, 255)) : THR_PLAN[ph];
            write_threshold(thr);

            // Flat run at the current mean: window collapses to zero deviation,
            // then any step off the mean must flag.
            if (ph % 2 == 0)
            begin
                flat_level = held_mean[15:0];
                for (int i = 0; i < LAG; i++)
                    queue_sample(flat_level);
                queue_sample(flat_level);
                if (flat_level != 16'hFFFF)
                    queue_sample(flat_level + 16'd1);
                if (flat_level != 16'h0000)
                    queue_sample(flat_level - 16'd1);
                queue_sample(16'hFFFF);
                queue_sample(16'h0000);
            end

            // Noisy signal around a drifting level with occasional spikes.
            base   = $urandom_range(0, 65535);
            spread = 4 << (3 * $urandom_range(0, 3));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    level = $urandom_range(0, 65535);
                else if (pick < 10)
                    level = pick[0] ? 65535 : 0;
                else
                begin
                    if (pick < 13)
                        base = $urandom_range(0, 65535);
                    level = base + int'($urandom_range(0, 2 * spread)) - spread;
                    if (level < 0)
                        level = 0;
                    if (level > 65535)
                        level = 65535;
                end
                queue_sample(level[15:0]);
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
